>>> rtl/qalu_pkg.sv
package qalu_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int WORD_BITS  = 32;
  localparam int QUO_BITS   = WORD_BITS + FRAC_BITS;
  localparam int DIV_STAGES = QUO_BITS;
  localparam int MAG_W      = 2 * WORD_BITS;

  localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'd1 << (WORD_BITS - 1));
  localparam logic [MAG_W-1:0] MUL_HALF    = MAG_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_GT     = 4'd4,
    CMD_LT     = 4'd5,
    CMD_GE     = 4'd6,
    CMD_LE     = 4'd7,
    CMD_EQ     = 4'd8,
    CMD_NE     = 4'd9,
    CMD_MIN    = 4'd10,
    CMD_MAX    = 4'd11,
    CMD_INC    = 4'd12,
    CMD_DEC    = 4'd13,
    CMD_TO_INT = 4'd14
  } cmd_e;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OVERFLOW = 2'd1,
    FAULT_DIV_ZERO = 2'd2
  } fault_e;

  typedef struct packed {
    logic [3:0]                  cmd;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_value;
    logic                        compare_true;
    logic [1:0]                  fault_code;
  } alu_out_t;

  // one divider stage: partial remainder, numerator bits shifting out on top
  // while quotient bits shift in at the bottom
  typedef struct packed {
    logic                  valid;
    logic                  div_go;
    logic                  neg;
    logic [WORD_BITS-1:0]  den;
    logic [WORD_BITS-1:0]  rem;
    logic [QUO_BITS-1:0]   nq;
    alu_out_t              side;
  } div_stage_t;

  function automatic alu_out_t sat_mag(input logic [MAG_W-1:0] q, input logic neg);
    alu_out_t r;
    r.compare_true = 1'b0;
    r.fault_code   = FAULT_NONE;
    if (neg) begin
      if (q > MAG_NEG_MAX) begin
        r.result_value = WORD_MIN;
        r.fault_code   = FAULT_OVERFLOW;
      end else begin
        r.result_value = -$signed(q[WORD_BITS-1:0]);
      end
    end else begin
      if (q > MAG_POS_MAX) begin
        r.result_value = WORD_MAX;
        r.fault_code   = FAULT_OVERFLOW;
      end else begin
        r.result_value = $signed(q[WORD_BITS-1:0]);
      end
    end
    return r;
  endfunction

  function automatic alu_out_t sat_sum(input logic signed [WORD_BITS:0] v);
    alu_out_t r;
    r.compare_true = 1'b0;
    r.fault_code   = FAULT_NONE;
    r.result_value = v[WORD_BITS-1:0];
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r.fault_code   = FAULT_OVERFLOW;
      r.result_value = v[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

endpackage

>>> rtl/qalu_div_step.sv
module qalu_div_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  qalu_pkg::div_stage_t   stage_i,
  output qalu_pkg::div_stage_t   stage_o
);
  import qalu_pkg::*;

  div_stage_t          stage_r;
  div_stage_t          stage_nxt;
  logic [WORD_BITS:0]  shifted;
  logic                take;

  always_comb begin
    shifted   = {stage_i.rem, stage_i.nq[QUO_BITS-1]};
    take      = shifted >= {1'b0, stage_i.den};
    stage_nxt = stage_i;
    stage_nxt.rem = take ? WORD_BITS'(shifted - {1'b0, stage_i.den}) : shifted[WORD_BITS-1:0];
    stage_nxt.nq  = {stage_i.nq[QUO_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

>>> rtl/q24_8_fixed_point_alu.sv
// Channel | Ports                        | Moves
// in      | in_valid, in_ready, in_data  | one request: cmd, operand_a, operand_b
// out     | out_valid, out_ready, out_data | one result: value, compare flag, fault
//
// All opcodes take the same path; one request per cycle unless out stalls.
// The 40 one-bit restoring divider stages set the depth; all opcodes ride along.
// Reset (rst_n low, synchronous) empties the pipeline.
// A stall on out freezes every stage at once; in_ready drops in the same cycle.
module q24_8_fixed_point_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qalu_pkg::alu_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qalu_pkg::alu_out_t out_data
);
  import qalu_pkg::*;

  typedef struct packed {
    logic                        valid;
    logic [3:0]                  cmd;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0]        mag_a;
    logic [WORD_BITS-1:0]        mag_b;
    logic                        neg;
  } s1_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_mul;
    logic                 div_go;
    logic                 neg;
    logic [MAG_W-1:0]     prod;
    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    alu_out_t             side;
  } s2_t;

  typedef struct packed {
    logic                 valid;
    logic                 div_go;
    logic                 neg;
    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    alu_out_t             side;
  } s3_t;

  s1_t        s1_r, s1_nxt;
  s2_t        s2_r, s2_nxt;
  s3_t        s3_r, s3_nxt;
  logic       out_valid_r, out_valid_nxt;
  alu_out_t   out_r, out_nxt;
  logic       en;
  div_stage_t chain [0:DIV_STAGES];
  logic [QUO_BITS:0] quo;
  logic              round_up;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: register operands and magnitudes
  always_comb begin
    s1_nxt.valid = in_valid;
    s1_nxt.cmd   = in_data.cmd;
    s1_nxt.a     = in_data.operand_a;
    s1_nxt.b     = in_data.operand_b;
    s1_nxt.mag_a = in_data.operand_a[WORD_BITS-1] ? WORD_BITS'(-in_data.operand_a)
                                                  : in_data.operand_a;
    s1_nxt.mag_b = in_data.operand_b[WORD_BITS-1] ? WORD_BITS'(-in_data.operand_b)
                                                  : in_data.operand_b;
    s1_nxt.neg   = in_data.operand_a[WORD_BITS-1] ^ in_data.operand_b[WORD_BITS-1];
  end

  // stage 2: multiply, and finish every opcode but MUL and nonzero DIV
  always_comb begin
    logic [WORD_BITS-1:0] int_mag;
    int_mag        = s1_r.mag_a >> FRAC_BITS;
    s2_nxt.valid   = s1_r.valid;
    s2_nxt.is_mul  = cmd_e'(s1_r.cmd) == CMD_MUL;
    s2_nxt.div_go  = cmd_e'(s1_r.cmd) == CMD_DIV && s1_r.b != '0;
    s2_nxt.neg     = s1_r.neg;
    s2_nxt.prod    = MAG_W'(s1_r.mag_a) * MAG_W'(s1_r.mag_b);
    s2_nxt.mag_a   = s1_r.mag_a;
    s2_nxt.mag_b   = s1_r.mag_b;
    s2_nxt.side    = '0;
    case (cmd_e'(s1_r.cmd))
      CMD_ADD: s2_nxt.side = sat_sum((WORD_BITS+1)'(s1_r.a) + (WORD_BITS+1)'(s1_r.b));
      CMD_SUB: s2_nxt.side = sat_sum((WORD_BITS+1)'(s1_r.a) - (WORD_BITS+1)'(s1_r.b));
      CMD_INC: s2_nxt.side = sat_sum((WORD_BITS+1)'(s1_r.a) + (WORD_BITS+1)'(1));
      CMD_DEC: s2_nxt.side = sat_sum((WORD_BITS+1)'(s1_r.a) - (WORD_BITS+1)'(1));
      CMD_DIV: begin
        if (s1_r.b == '0) begin
          s2_nxt.side.fault_code   = FAULT_DIV_ZERO;
          s2_nxt.side.result_value = s1_r.a[WORD_BITS-1] ? WORD_MIN
                                   : (s1_r.a == '0 ? '0 : WORD_MAX);
        end
      end
      CMD_GT:  s2_nxt.side.compare_true = s1_r.a >  s1_r.b;
      CMD_LT:  s2_nxt.side.compare_true = s1_r.a <  s1_r.b;
      CMD_GE:  s2_nxt.side.compare_true = s1_r.a >= s1_r.b;
      CMD_LE:  s2_nxt.side.compare_true = s1_r.a <= s1_r.b;
      CMD_EQ:  s2_nxt.side.compare_true = s1_r.a == s1_r.b;
      CMD_NE:  s2_nxt.side.compare_true = s1_r.a != s1_r.b;
      CMD_MIN: s2_nxt.side.result_value = (s1_r.a < s1_r.b) ? s1_r.a : s1_r.b;
      CMD_MAX: s2_nxt.side.result_value = (s1_r.a > s1_r.b) ? s1_r.a : s1_r.b;
      CMD_TO_INT: s2_nxt.side.result_value = s1_r.a[WORD_BITS-1] ? -$signed(int_mag)
                                                               : $signed(int_mag);
      default: s2_nxt.side = '0;
    endcase
  end

  // stage 3: round and saturate the product
  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.div_go = s2_r.div_go;
    s3_nxt.neg    = s2_r.neg;
    s3_nxt.mag_a  = s2_r.mag_a;
    s3_nxt.mag_b  = s2_r.mag_b;
    s3_nxt.side   = s2_r.is_mul ? sat_mag((s2_r.prod + MUL_HALF) >> FRAC_BITS, s2_r.neg)
                                : s2_r.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  always_comb begin
    chain[0].valid  = s3_r.valid;
    chain[0].div_go = s3_r.div_go;
    chain[0].neg    = s3_r.neg;
    chain[0].den    = s3_r.mag_b;
    chain[0].rem    = '0;
    chain[0].nq     = {s3_r.mag_a, {FRAC_BITS{1'b0}}};
    chain[0].side   = s3_r.side;
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    qalu_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // final stage: round the quotient half away from zero
  always_comb begin
    round_up      = {chain[DIV_STAGES].rem, 1'b0} >= {1'b0, chain[DIV_STAGES].den};
    quo           = {1'b0, chain[DIV_STAGES].nq} + (QUO_BITS+1)'(round_up);
    out_valid_nxt = chain[DIV_STAGES].valid;
    out_nxt       = chain[DIV_STAGES].div_go
                  ? sat_mag(MAG_W'(quo), chain[DIV_STAGES].neg)
                  : chain[DIV_STAGES].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
